>>> src/powerpc_branch_facility_defines.svh
// Assertion macros shared by the branch facility modules.
// Included by the modules that check their own logic; needs no package.
`ifndef POWERPC_BRANCH_FACILITY_DEFINES_SVH
`define POWERPC_BRANCH_FACILITY_DEFINES_SVH
`ifndef SYNTH
`define PBF_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("branch facility assertion failed");
`define PBF_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("branch facility forbidden condition");
`else
`define PBF_ASSERT(label, clk, rst_n, prop)
`define PBF_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

>>> src/pbf_pkg.sv
// Shared types and constants of the branch facility: opcodes, status codes,
// decoded instruction record. Used by the front end, back end and top; depends on nothing.
package pbf_pkg;

	localparam int IN_TDATA_W  = 96;
	localparam int OUT_TDATA_W = 232;
	localparam int FIFO_DEPTH  = 2;

	localparam logic [5:0] OPC_BC = 6'd16;
	localparam logic [5:0] OPC_B  = 6'd18;
	localparam logic [5:0] OPC_XL = 6'd19;

	localparam logic [9:0] XO_MCRF   = 10'd0;
	localparam logic [9:0] XO_BCLR   = 10'd16;
	localparam logic [9:0] XO_CRNOR  = 10'd33;
	localparam logic [9:0] XO_CRANDC = 10'd129;
	localparam logic [9:0] XO_CRXOR  = 10'd193;
	localparam logic [9:0] XO_CRNAND = 10'd225;
	localparam logic [9:0] XO_CRAND  = 10'd257;
	localparam logic [9:0] XO_CREQV  = 10'd289;
	localparam logic [9:0] XO_CRORC  = 10'd417;
	localparam logic [9:0] XO_CROR   = 10'd449;
	localparam logic [9:0] XO_BCCTR  = 10'd528;

	// CR logical ops as truth tables indexed by {a, b}
	localparam logic [3:0] TT_AND  = 4'b1000;
	localparam logic [3:0] TT_OR   = 4'b1110;
	localparam logic [3:0] TT_XOR  = 4'b0110;
	localparam logic [3:0] TT_NAND = 4'b0111;
	localparam logic [3:0] TT_NOR  = 4'b0001;
	localparam logic [3:0] TT_EQV  = 4'b1001;
	localparam logic [3:0] TT_ANDC = 4'b0100;
	localparam logic [3:0] TT_ORC  = 4'b1101;

	localparam logic [1:0] ST_EXEC   = 2'd0;
	localparam logic [1:0] ST_NOT_BF = 2'd1;
	localparam logic [1:0] ST_BAD_XO = 2'd2;

	typedef enum logic [2:0] {
		KIND_B,
		KIND_BC,
		KIND_BCLR,
		KIND_BCCTR,
		KIND_CRLOG,
		KIND_MCRF,
		KIND_NONE
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [1:0]  status;
		logic [4:0]  bo;
		logic [4:0]  bi;
		logic [4:0]  bb;
		logic [2:0]  bf;
		logic [2:0]  bfa;
		logic [3:0]  tt;
		logic        lk;
		logic [63:0] seq;
		logic [63:0] target;
	} decoded_t;

endpackage

>>> src/pbf_front.sv
// Front end: accepts instruction transactions, decodes them and computes
// the sequential and immediate targets. Depends on pbf_pkg.
module pbf_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [31:0] instruction_word, [95:32] current_address
	input  logic [pbf_pkg::IN_TDATA_W-1:0] s_tdata,
	output logic                           push,
	input  logic                           push_ready,
	output pbf_pkg::decoded_t              push_item
);

	logic              valid_s1;
	pbf_pkg::decoded_t item_s1;
	pbf_pkg::decoded_t dec;
	logic [31:0]       w;
	logic [63:0]       cia;
	logic [63:0]       disp;

	assign w   = s_tdata[31:0];
	assign cia = s_tdata[95:32];

	always_comb begin
		dec.kind   = pbf_pkg::KIND_NONE;
		dec.status = pbf_pkg::ST_EXEC;
		dec.bo     = w[25:21];
		dec.bi     = w[20:16];
		dec.bb     = w[15:11];
		dec.bf     = w[25:23];
		dec.bfa    = w[20:18];
		dec.tt     = pbf_pkg::TT_AND;
		dec.lk     = w[0];
		dec.seq    = cia + 64'd4;
		// 24-bit LI for b, 14-bit BD for bc, both word scaled
		disp = (w[31:26] == pbf_pkg::OPC_B) ? {{38{w[25]}}, w[25:2], 2'b00}
			: {{48{w[15]}}, w[15:2], 2'b00};
		dec.target = w[1] ? disp : cia + disp;
		case (w[31:26])
			pbf_pkg::OPC_B:  dec.kind = pbf_pkg::KIND_B;
			pbf_pkg::OPC_BC: dec.kind = pbf_pkg::KIND_BC;
			pbf_pkg::OPC_XL: begin
				case (w[10:1])
					pbf_pkg::XO_BCLR:   dec.kind = pbf_pkg::KIND_BCLR;
					pbf_pkg::XO_BCCTR:  dec.kind = pbf_pkg::KIND_BCCTR;
					pbf_pkg::XO_MCRF:   dec.kind = pbf_pkg::KIND_MCRF;
					pbf_pkg::XO_CRAND: begin
						dec.kind = pbf_pkg::KIND_CRLOG;
						dec.tt   = pbf_pkg::TT_AND;
					end
					pbf_pkg::XO_CROR: begin
						dec.kind = pbf_pkg::KIND_CRLOG;
						dec.tt   = pbf_pkg::TT_OR;
					end
					pbf_pkg::XO_CRXOR: begin
						dec.kind = pbf_pkg::KIND_CRLOG;
						dec.tt   = pbf_pkg::TT_XOR;
					end
					pbf_pkg::XO_CRNAND: begin
						dec.kind = pbf_pkg::KIND_CRLOG;
						dec.tt   = pbf_pkg::TT_NAND;
					end
					pbf_pkg::XO_CRNOR: begin
						dec.kind = pbf_pkg::KIND_CRLOG;
						dec.tt   = pbf_pkg::TT_NOR;
					end
					pbf_pkg::XO_CREQV: begin
						dec.kind = pbf_pkg::KIND_CRLOG;
						dec.tt   = pbf_pkg::TT_EQV;
					end
					pbf_pkg::XO_CRANDC: begin
						dec.kind = pbf_pkg::KIND_CRLOG;
						dec.tt   = pbf_pkg::TT_ANDC;
					end
					pbf_pkg::XO_CRORC: begin
						dec.kind = pbf_pkg::KIND_CRLOG;
						dec.tt   = pbf_pkg::TT_ORC;
					end
					default: dec.status = pbf_pkg::ST_BAD_XO;
				endcase
			end
			default: dec.status = pbf_pkg::ST_NOT_BF;
		endcase
	end

	assign s_tready  = !valid_s1 || push_ready;
	assign push      = valid_s1 && push_ready;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= dec;
		end
	end

endmodule

>>> src/pbf_queue.sv
// Short register queue between front and back ends.
// Generic width and depth; uses the assertion macros header.
`include "powerpc_branch_facility_defines.svh"

module pbf_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             push_ready,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             pop_valid
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	`PBF_ASSERT_NEVER(a_push_full, clk, arst_n, push && !push_ready)
	`PBF_ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && !pop_valid)
	`PBF_ASSERT_NEVER(a_count_range, clk, arst_n, count_q > CNT_W'(DEPTH))

endmodule

>>> src/pbf_back.sv
// Back end: executes decoded branch and CR ops against CR, LR and CTR and
// holds the result until taken. Depends on pbf_pkg and the macros header.
`include "powerpc_branch_facility_defines.svh"

module pbf_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  pbf_pkg::decoded_t               item,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [63:0] next_address, [64] redirected, [66:65] status,
	// [130:67] link_value, [194:131] count_value, [226:195] condition_value
	output logic [pbf_pkg::OUT_TDATA_W-1:0] m_tdata
);

	logic        out_valid_q;
	logic [63:0] nia_q;
	logic        redirected_q;
	logic [1:0]  status_q;
	logic [31:0] cr_q;
	logic [63:0] lr_q;
	logic [63:0] ctr_q;

	logic        pop;
	logic        is_branch;
	logic        ctr_dec;
	logic        ctr_nz;
	logic        ctr_ok;
	logic        cond_ok;
	logic        taken;
	logic        bit_a;
	logic        bit_b;
	logic [31:0] cr_next;
	logic [63:0] lr_next;
	logic [63:0] ctr_next;
	logic [63:0] nia;
	logic [3:0]  nib_src;

	assign in_ready = !out_valid_q || m_tready;
	assign pop      = in_valid && in_ready;

	always_comb begin
		is_branch = (item.kind == pbf_pkg::KIND_B) || (item.kind == pbf_pkg::KIND_BC)
			|| (item.kind == pbf_pkg::KIND_BCLR) || (item.kind == pbf_pkg::KIND_BCCTR);
		// bcctr never touches CTR; other conditional branches decrement when BO_2 clear
		ctr_dec  = ((item.kind == pbf_pkg::KIND_BC) || (item.kind == pbf_pkg::KIND_BCLR))
			&& !item.bo[2];
		ctr_nz   = ctr_dec ? (ctr_q != 64'd1) : (ctr_q != 64'd0);
		ctr_ok   = (item.kind == pbf_pkg::KIND_BCCTR) || item.bo[2] || (ctr_nz ^ item.bo[1]);
		bit_a    = cr_q[~item.bi];
		bit_b    = cr_q[~item.bb];
		cond_ok  = item.bo[4] || (bit_a == item.bo[3]);
		taken    = (item.kind == pbf_pkg::KIND_B) || (is_branch && ctr_ok && cond_ok);
		ctr_next = ctr_dec ? ctr_q - 64'd1 : ctr_q;
		lr_next  = (is_branch && item.lk) ? item.seq : lr_q;
		nib_src  = cr_q[{~item.bfa, 2'b00} +: 4];

		cr_next = cr_q;
		if (item.kind == pbf_pkg::KIND_CRLOG) begin
			cr_next[~item.bo] = item.tt[{bit_a, bit_b}];
		end else if (item.kind == pbf_pkg::KIND_MCRF) begin
			cr_next[{~item.bf, 2'b00} +: 4] = nib_src;
		end

		nia = item.seq;
		if (taken) begin
			case (item.kind)
				pbf_pkg::KIND_BCLR:  nia = {lr_q[63:2], 2'b00};
				pbf_pkg::KIND_BCCTR: nia = {ctr_q[63:2], 2'b00};
				default:             nia = item.target;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cr_q        <= '0;
			lr_q        <= '0;
			ctr_q       <= '0;
		end else begin
			if (in_ready) begin
				out_valid_q <= in_valid;
			end
			if (pop) begin
				cr_q  <= cr_next;
				lr_q  <= lr_next;
				ctr_q <= ctr_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			nia_q        <= nia;
			redirected_q <= taken;
			status_q     <= item.status;
		end
	end

	// state only moves on a pop, so it always matches the held result
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, cr_q, ctr_q, lr_q, status_q, redirected_q, nia_q};

	`PBF_ASSERT_NEVER(a_redirect_status, clk, arst_n,
		out_valid_q && redirected_q && (status_q != pbf_pkg::ST_EXEC))
	`PBF_ASSERT(a_nop_keeps_state, clk, arst_n,
		(pop && (item.status != pbf_pkg::ST_EXEC))
		|=> ($stable(cr_q) && $stable(lr_q) && $stable(ctr_q)))
	`PBF_ASSERT(a_result_hold, clk, arst_n,
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))

endmodule

>>> src/powerpc_branch_facility.sv
// Branch facility: b, bc, bclr, bcctr, CR logical ops and mcrf.
// Throughput one instruction per cycle when the output is not stalled, set by the
// execute stage that reads and writes CR, LR and CTR. A result is offered after
// its instruction passes the decode register, the queue and the result register.
// Reset clears CR, LR and CTR to zero and empties the decode stage and queue.
module powerpc_branch_facility #(
	parameter int QUEUE_DEPTH = pbf_pkg::FIFO_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [31:0] instruction_word, [95:32] current_address
	input  logic [pbf_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [63:0] next_address, [64] redirected, [66:65] status,
	// [130:67] link_value, [194:131] count_value, [226:195] condition_value
	output logic [pbf_pkg::OUT_TDATA_W-1:0] m_tdata
);

	localparam int ITEM_W = $bits(pbf_pkg::decoded_t);

	logic              push;
	logic              push_ready;
	pbf_pkg::decoded_t push_item;
	logic [ITEM_W-1:0] pop_data;
	logic              pop_valid;
	logic              back_ready;

	pbf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.push       (push),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	pbf_queue #(
		.WIDTH (ITEM_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_item),
		.push_ready (push_ready),
		.pop        (pop_valid && back_ready),
		.pop_data   (pop_data),
		.pop_valid  (pop_valid)
	);

	pbf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pop_valid),
		.in_ready (back_ready),
		.item     (pbf_pkg::decoded_t'(pop_data)),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
